FILE: src/fra_pkg.sv
package fra_pkg;

    localparam int FRAME_SLOTS_DEF = 8;
    localparam logic [31:0] CAP_RESET = 32'd65536;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_RELEASE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_QFULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] fence;
        logic [31:0] head;
        logic [31:0] bytes;
    } frame_rec_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } q_ctl_t;

endpackage

FILE: src/fra_if.sv
interface fra_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] request_size;
    logic [31:0] alignment;
    logic [63:0] fence;

    modport source (output valid, op, request_size, alignment, fence, input ready);
    modport sink (input valid, op, request_size, alignment, fence, output ready);
endinterface

interface fra_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] offset;
    logic [31:0] used_bytes;
    logic [3:0]  pending_frames;

    modport source (output valid, status, offset, used_bytes, pending_frames, input ready);
    modport sink (input valid, status, offset, used_bytes, pending_frames, output ready);
endinterface

FILE: src/fra_frame_queue.sv
module fra_frame_queue #(
    parameter int FRAME_SLOTS = fra_pkg::FRAME_SLOTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fra_pkg::q_ctl_t                    ctl,
    input  fra_pkg::frame_rec_t                wr_rec,
    output fra_pkg::frame_rec_t                head_rec,
    output logic [$clog2(FRAME_SLOTS+1)-1:0]   count,
    output logic                               full
);
    import fra_pkg::*;

    localparam int PTR_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(FRAME_SLOTS - 1);

    frame_rec_t mem [FRAME_SLOTS];

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        priority if (ctl.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            cnt_next    = '0;
        end
        else
        begin
            if (ctl.push)
                wr_ptr_next = ptr_inc(wr_ptr_reg);
            if (ctl.pop)
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            unique case ({ctl.push, ctl.pop})
                2'b10:   cnt_next = cnt_reg + 1'b1;
                2'b01:   cnt_next = cnt_reg - 1'b1;
                default: cnt_next = cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // read the next oldest entry every cycle so it is ready for the pop check
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            mem[wr_ptr_reg] <= wr_rec;
        head_rec <= mem[rd_ptr_next];
    end

    assign count = cnt_reg;
    assign full  = (cnt_reg == CNT_W'(FRAME_SLOTS));

endmodule

FILE: src/fenced_ring_allocator_top.sv
// Allocate: steps through ALC1, ALC2 and ALC3; the result is registered on leaving ALC3
// once the output is free. Complete frame (and unused op): the result is registered from
// CMP once the output is free. Release: one pop per cycle through the frame queue memory
// read port while the head fence passes, then the result once the output is free.
// New items are taken only in idle. Reset: head, tail, used, frame byte counts, queue
// pointers clear, capacity returns to 65536; queue memory contents are left alone.
module fenced_ring_allocator_top #(
    parameter int FRAME_SLOTS = fra_pkg::FRAME_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    fra_cmd_if.sink     cmd,
    fra_rsp_if.source   rsp
);
    import fra_pkg::*;

    localparam int CNT_W = $clog2(FRAME_SLOTS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ALC1 = 6'b000010,
        S_ALC2 = 6'b000100,
        S_ALC3 = 6'b001000,
        S_CMP  = 6'b010000,
        S_RLS  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [31:0] req_reg, align_reg;
    logic [63:0] fence_reg;

    logic [31:0] cap_reg;
    logic [31:0] head_reg, head_next;
    logic [31:0] tail_reg, tail_next;
    logic [31:0] used_reg, used_next;
    logic [31:0] fb_reg, fb_next;

    // first allocate stage
    logic [32:0] size_reg, ahead_reg;
    logic [31:0] gap_reg, skip_reg;
    logic        err_reg;
    status_t     err_st_reg;

    // second allocate stage
    logic        grant_reg;
    logic [31:0] nhead_reg;
    logic [33:0] added_reg;
    status_t     res_st_reg;
    logic [31:0] res_off_reg;

    logic        out_valid_reg;
    status_t     out_st_reg, out_st_next;
    logic [31:0] out_off_reg, out_off_next;
    logic [31:0] out_used_reg, out_used_next;
    logic [3:0]  out_pend_reg, out_pend_next;
    logic        out_load;
    logic        out_free;
    logic        accept;

    q_ctl_t      q_ctl;
    frame_rec_t  q_head;
    frame_rec_t  q_wr;
    logic [CNT_W-1:0] q_count;
    logic        q_full;

    assign accept   = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE);

    fra_frame_queue #(.FRAME_SLOTS(FRAME_SLOTS)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (q_ctl),
        .wr_rec   (q_wr),
        .head_rec (q_head),
        .count    (q_count),
        .full     (q_full)
    );

    assign q_wr = '{fence: fence_reg, head: head_reg, bytes: fb_reg};

    // stage 1: round size and head, gap to the aligned head, space skipped on wrap
    logic [31:0] amask;
    logic [32:0] size_s, ahead_s;
    logic [31:0] gap_s, skip_s;
    logic        bad_al;
    logic        err_s;
    status_t     err_st_s;

    assign amask   = align_reg - 32'd1;
    assign size_s  = ({1'b0, req_reg} + {1'b0, amask}) & ~{1'b0, amask};
    assign ahead_s = ({1'b0, head_reg} + {1'b0, amask}) & ~{1'b0, amask};
    assign gap_s   = (32'd0 - head_reg) & amask;
    assign skip_s  = (cap_reg > head_reg) ? (cap_reg - head_reg) : 32'd0;
    assign bad_al  = (align_reg == 32'd0) || ((align_reg & amask) != 32'd0);

    always_comb
    begin
        err_s    = 1'b1;
        err_st_s = ST_BAD;
        priority if (req_reg == 32'd0)
            err_st_s = ST_BAD;
        else if (used_reg == cap_reg)
            err_st_s = ST_NOSPACE;
        else if (bad_al)
            err_st_s = ST_BAD;
        else
            err_s = 1'b0;
    end

    // stage 2: fit checks and placement
    logic [33:0] sum_ah, add_fit, add_wrap;
    logic        over, fit_cap, wrap_ok, fit_tail;
    logic        a2_grant;
    status_t     a2_st;
    logic [31:0] a2_off, a2_nhead;
    logic [33:0] a2_add;

    assign over     = ({2'b0, used_reg} + {1'b0, size_reg}) > {2'b0, cap_reg};
    assign sum_ah   = {1'b0, ahead_reg} + {1'b0, size_reg};
    assign fit_cap  = sum_ah <= {2'b0, cap_reg};
    assign fit_tail = sum_ah <= {2'b0, tail_reg};
    assign wrap_ok  = size_reg <= {1'b0, tail_reg};
    assign add_fit  = {1'b0, size_reg} + {2'b0, gap_reg};
    assign add_wrap = {1'b0, size_reg} + {2'b0, skip_reg};

    always_comb
    begin
        a2_grant = 1'b0;
        a2_st    = ST_NOSPACE;
        a2_off   = 32'd0;
        a2_nhead = sum_ah[31:0];
        a2_add   = add_fit;
        priority if (err_reg)
            a2_st = err_st_reg;
        else if (over)
            a2_st = ST_NOSPACE;
        else if (head_reg >= tail_reg)
        begin
            priority if (fit_cap)
            begin
                a2_grant = 1'b1;
                a2_st    = ST_OK;
                a2_off   = ahead_reg[31:0];
            end
            else if (wrap_ok)
            begin
                // restart at offset zero, the space past the head is lost
                a2_grant = 1'b1;
                a2_st    = ST_OK;
                a2_nhead = size_reg[31:0];
                a2_add   = add_wrap;
            end
            else
                a2_st = ST_NOSPACE;
        end
        else if (fit_tail)
        begin
            a2_grant = 1'b1;
            a2_st    = ST_OK;
            a2_off   = ahead_reg[31:0];
        end
        else
            a2_st = ST_NOSPACE;
    end

    // stage 3: saturating counter updates
    logic [34:0] used_sum, fb_sum;
    logic [31:0] used_sat, fb_sat;

    assign used_sum = {3'b0, used_reg} + {1'b0, added_reg};
    assign fb_sum   = {3'b0, fb_reg} + {1'b0, added_reg};
    assign used_sat = (used_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : used_sum[31:0];
    assign fb_sat   = (fb_sum[34:32] != 3'd0) ? 32'hFFFF_FFFF : fb_sum[31:0];

    // release
    logic        pop_ok;
    logic [31:0] rel_used;

    assign pop_ok   = (q_count != '0) && (q_head.fence <= fence_reg);
    assign rel_used = (q_head.bytes > used_reg) ? 32'd0 : (used_reg - q_head.bytes);

    logic [31:0] cnt_ext, cnt_inc_ext;

    assign cnt_ext     = 32'(q_count);
    assign cnt_inc_ext = 32'(q_count) + 32'd1;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        used_next     = used_reg;
        fb_next       = fb_reg;
        q_ctl         = '0;
        out_load      = 1'b0;
        out_st_next   = ST_OK;
        out_off_next  = 32'd0;
        out_used_next = used_reg;
        out_pend_next = cnt_ext[3:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_ALLOC:   state_next = S_ALC1;
                        OP_RELEASE: state_next = S_RLS;
                        default:    state_next = S_CMP;
                    endcase
                end
            end
            S_ALC1:
                state_next = S_ALC2;
            S_ALC2:
                state_next = S_ALC3;
            S_ALC3:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_st_next  = res_st_reg;
                    out_off_next = res_off_reg;
                    state_next   = S_IDLE;
                    if (grant_reg)
                    begin
                        head_next     = nhead_reg;
                        used_next     = used_sat;
                        fb_next       = fb_sat;
                        out_used_next = used_sat;
                    end
                end
            end
            S_CMP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_COMPLETE && fb_reg != 32'd0)
                    begin
                        if (q_full)
                            out_st_next = ST_QFULL;
                        else
                        begin
                            q_ctl.push    = 1'b1;
                            fb_next       = 32'd0;
                            out_pend_next = cnt_inc_ext[3:0];
                        end
                    end
                end
            end
            S_RLS:
            begin
                if (pop_ok)
                begin
                    q_ctl.pop = 1'b1;
                    used_next = rel_used;
                    tail_next = q_head.head;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    // empty buffer: snap tail to head and drop the queue
                    if (used_reg == 32'd0)
                    begin
                        q_ctl.clear   = 1'b1;
                        tail_next     = head_reg;
                        out_pend_next = 4'd0;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= 32'd0;
            tail_reg      <= 32'd0;
            used_reg      <= 32'd0;
            fb_reg        <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            used_reg  <= used_next;
            fb_reg    <= fb_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.op;
            req_reg   <= cmd.request_size;
            align_reg <= cmd.alignment;
            fence_reg <= cmd.fence;
        end
        if (state_reg == S_ALC1)
        begin
            size_reg   <= size_s;
            ahead_reg  <= ahead_s;
            gap_reg    <= gap_s;
            skip_reg   <= skip_s;
            err_reg    <= err_s;
            err_st_reg <= err_st_s;
        end
        if (state_reg == S_ALC2)
        begin
            grant_reg   <= a2_grant;
            res_st_reg  <= a2_st;
            res_off_reg <= a2_off;
            nhead_reg   <= a2_nhead;
            added_reg   <= a2_add;
        end
        if (out_load)
        begin
            out_st_reg   <= out_st_next;
            out_off_reg  <= out_off_next;
            out_used_reg <= out_used_next;
            out_pend_reg <= out_pend_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_st_reg;
    assign rsp.offset         = out_off_reg;
    assign rsp.used_bytes     = out_used_reg;
    assign rsp.pending_frames = out_pend_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(FRAME_SLOTS))
        else $error("frame queue count above slot count");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctl.pop |-> (q_count != '0) && !q_ctl.push && !q_ctl.clear)
        else $error("pop from empty queue or mixed with push or clear");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALC3 && grant_reg) |-> (res_st_reg == ST_OK))
        else $error("granted allocation without ok status");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_ctl.push |=> (q_count != '0) && (fb_reg == 32'd0))
        else $error("push did not register a frame");

endmodule

FILE: tb/sv/fra_tb_pkg.sv
`timescale 1ns / 100ps

package fra_tb_pkg;
    import fra_pkg::*;

    typedef struct {
        status_t     status;
        logic [31:0] offset;
        logic [31:0] used_bytes;
        logic [3:0]  pending_frames;
    } ring_reply_t;

    class ring_alloc_checker;
        logic [31:0] capacity;
        logic [31:0] head;
        logic [31:0] tail;
        logic [31:0] used;
        logic [31:0] frame_bytes;
        frame_rec_t  frames [FRAME_SLOTS_DEF];
        int unsigned rd_ptr;
        int unsigned wr_ptr;
        int unsigned queued;
        ring_reply_t awaited_replies[$];
        int unsigned mismatches;
        int unsigned replies_checked;
        int unsigned status_tally [4];

        function new();
            capacity = CAP_RESET;
            head = '0;
            tail = '0;
            used = '0;
            frame_bytes = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            queued = 0;
            mismatches = 0;
            replies_checked = 0;
            foreach (status_tally[i])
                status_tally[i] = 0;
        endfunction

        function void set_capacity(logic [31:0] value);
            capacity = value;
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [63:0] b);
            logic [63:0] s;
            s = {32'd0, a} + b;
            return (s > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [63:0] round_up(logic [63:0] v, logic [63:0] a);
            return (v + a - 64'd1) & ~(a - 64'd1);
        endfunction

        function void take_bytes(logic [63:0] new_head, logic [63:0] added);
            head = new_head[31:0];
            used = sat_add(used, added);
            frame_bytes = sat_add(frame_bytes, added);
        endfunction

        function status_t allocate(logic [31:0] req, logic [31:0] align,
                                   output logic [31:0] offset);
            logic [63:0] cap64;
            logic [63:0] head64;
            logic [63:0] tail64;
            logic [63:0] size;
            logic [63:0] ahead;
            logic [63:0] skip;
            offset = '0;
            cap64 = {32'd0, capacity};
            head64 = {32'd0, head};
            tail64 = {32'd0, tail};
            if (req == '0)
                return ST_BAD;
            // full region wins over a bad alignment
            if (used == capacity)
                return ST_NOSPACE;
            if (align == '0 || (align & (align - 32'd1)) != '0)
                return ST_BAD;
            size = round_up({32'd0, req}, {32'd0, align});
            if ({32'd0, used} + size > cap64)
                return ST_NOSPACE;
            ahead = round_up(head64, {32'd0, align});
            if (head64 >= tail64)
            begin
                if (ahead + size <= cap64)
                begin
                    offset = ahead[31:0];
                    take_bytes(ahead + size, size + (ahead - head64));
                    return ST_OK;
                end
                if (size <= tail64)
                begin
                    // wrap to 0; space past a head beyond capacity counts as nothing
                    skip = (cap64 > head64) ? cap64 - head64 : 64'd0;
                    take_bytes(size, skip + size);
                    return ST_OK;
                end
            end
            else if (ahead + size <= tail64)
            begin
                offset = ahead[31:0];
                take_bytes(ahead + size, size + (ahead - head64));
                return ST_OK;
            end
            return ST_NOSPACE;
        endfunction

        function status_t complete_frame(logic [63:0] fence);
            if (frame_bytes == '0)
                return ST_OK;
            // keep the frame open when the queue is full
            if (queued >= FRAME_SLOTS_DEF)
                return ST_QFULL;
            frames[wr_ptr].fence = fence;
            frames[wr_ptr].head = head;
            frames[wr_ptr].bytes = frame_bytes;
            wr_ptr = (wr_ptr + 1) % FRAME_SLOTS_DEF;
            queued++;
            frame_bytes = '0;
            return ST_OK;
        endfunction

        function void release_frames(logic [63:0] fence);
            while (queued > 0 && frames[rd_ptr].fence <= fence)
            begin
                used = (frames[rd_ptr].bytes > used) ? '0 : used - frames[rd_ptr].bytes;
                tail = frames[rd_ptr].head;
                rd_ptr = (rd_ptr + 1) % FRAME_SLOTS_DEF;
                queued--;
            end
            // empty ring: snap tail to head and drop the queue
            if (used == '0)
            begin
                queued = 0;
                rd_ptr = 0;
                wr_ptr = 0;
                tail = head;
            end
        endfunction

        function void note_item(logic [1:0] op, logic [31:0] req, logic [31:0] align,
                                logic [63:0] fence);
            ring_reply_t r;
            logic [31:0] off;
            r.status = ST_OK;
            off = '0;
            case (op)
                OP_ALLOC:    r.status = allocate(req, align, off);
                OP_COMPLETE: r.status = complete_frame(fence);
                OP_RELEASE:  release_frames(fence);
                default:     ;
            endcase
            r.offset = off;
            r.used_bytes = used;
            r.pending_frames = 4'(queued);
            status_tally[r.status]++;
            awaited_replies.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 40)
                $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [1:0] status, logic [31:0] offset, logic [31:0] used_bytes,
                          logic [3:0] pending_frames);
            ring_reply_t e;
            if (awaited_replies.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing outstanding: status %0d",
                                          status));
                return;
            end
            // take the oldest awaited reply
            e = awaited_replies[0];
            awaited_replies.delete(0);
            replies_checked++;
            if (status !== e.status)
                report_mismatch($sformatf("status %0d, want %0d", status, e.status));
            if (offset !== e.offset)
                report_mismatch($sformatf("offset 0x%08h, want 0x%08h", offset, e.offset));
            if (used_bytes !== e.used_bytes)
                report_mismatch($sformatf("used_bytes 0x%08h, want 0x%08h",
                                          used_bytes, e.used_bytes));
            if (pending_frames !== e.pending_frames)
                report_mismatch($sformatf("pending_frames %0d, want %0d",
                                          pending_frames, e.pending_frames));
        endtask
    endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fra_pkg::*;
    import fra_tb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    bit          idle_enabled = 1'b1;
    bit          long_hold_req = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    logic [63:0] next_fence = 64'd16;

    ring_alloc_checker sb = new();

    fra_cmd_if cmd ();
    fra_rsp_if rsp ();

    fenced_ring_allocator_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .rsp         (rsp)
    );

    always #1 clk = ~clk;

    // watch both channels; note the item before checking so order is kept
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
            sb.note_item(cmd.op, cmd.request_size, cmd.alignment, cmd.fence);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(rsp.status, rsp.offset, rsp.used_bytes, rsp.pending_frames);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.outstanding());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        int stall_left;
        rsp.ready = 1'b0;
        hold_left = 0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (idle_enabled && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] req,
                             input logic [31:0] align, input logic [63:0] fence);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.op <= op;
        cmd.request_size <= req;
        cmd.alignment <= align;
        cmd.fence <= fence;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // drop valid and hold until every result is back
    task automatic wait_idle();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_capacity(value);
    endtask

    function automatic logic [31:0] pick_size();
        int k;
        logic [31:0] span;
        k = $urandom_range(0, 99);
        span = sb.capacity / 6;
        if (span == '0)
            span = 32'd1;
        if (k < 3)
            return '0;
        if (k < 7)
            return $urandom;
        if (k < 9)
            return '1;
        return $urandom_range(span, 1);
    endfunction

    function automatic logic [31:0] pick_align();
        int k;
        k = $urandom_range(0, 99);
        if (k < 3)
            return '0;
        if (k < 6)
            return $urandom | 32'h3;
        if (k < 12)
            return 32'h1 << $urandom_range(0, 31);
        return 32'h1 << $urandom_range(0, 5);
    endfunction

    task automatic random_item();
        logic [1:0]  op;
        logic [63:0] fence;
        int k;
        k = $urandom_range(0, 99);
        fence = {$urandom, $urandom};
        if (k < 50)
            op = OP_ALLOC;
        else if (k < 72)
        begin
            op = OP_COMPLETE;
            fence = next_fence;
            next_fence += 64'd1;
        end
        else if (k < 92)
        begin
            // release a few frames behind the newest fence
            op = OP_RELEASE;
            fence = next_fence - 64'($urandom_range(1, 6));
        end
        else if (k < 94)
        begin
            op = OP_RELEASE;
            fence = '1;
        end
        else if (k < 97)
            op = OP_COMPLETE;
        else
            op = 2'($urandom_range(0, 3));
        send_item(op, pick_size(), pick_align(), fence);
    endtask

    task automatic directed_items();
        logic [31:0] fill;
        send_item(OP_ALLOC, 32'd0, 32'd1, '0);
        send_item(OP_ALLOC, 32'd16, 32'd0, '0);
        send_item(OP_ALLOC, 32'd16, 32'd24, '0);
        send_item(OP_ALLOC, 32'hFFFF_FFFF, 32'd1, '0);
        send_item(OP_ALLOC, 32'd1, 32'h8000_0000, '0);
        send_item(OP_COMPLETE, '0, '0, 64'd1);
        send_item(OP_UNUSED, '1, '1, '1);
        // fill the frame queue, then overflow it
        for (int i = 0; i < FRAME_SLOTS_DEF; i++)
        begin
            send_item(OP_ALLOC, 32'(5 + 3 * i), 32'h1 << (i % 4), '0);
            send_item(OP_COMPLETE, '0, '0, (i == FRAME_SLOTS_DEF - 1) ? 64'hFFFF_FFFF_FFFF_FFFE
                                                                       : 64'(i));
        end
        fill = sb.capacity - sb.head;
        send_item(OP_ALLOC, fill, 32'd1, '0);
        send_item(OP_ALLOC, 32'd1, 32'd1, '0);
        send_item(OP_COMPLETE, '0, '0, 64'd100);
    endtask

    task automatic random_phase(input logic [31:0] capacity, input int count);
        int unsigned target;
        write_capacity(capacity);
        target = items_sent + count;
        while (items_sent < target)
            random_item();
    endtask

    initial
    begin
        cmd.valid = 1'b0;
        cmd.op = OP_ALLOC;
        cmd.request_size = '0;
        cmd.alignment = '0;
        cmd.fence = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(32'd256);
        directed_items();

        random_phase(32'd4096, PHASE_ITEMS);
        long_hold_req = 1'b1;
        random_phase(32'd4096, PHASE_ITEMS);
        // lower the capacity under a head that may sit past it
        random_phase(32'd64, PHASE_ITEMS);
        random_phase(32'd300, PHASE_ITEMS);
        random_phase(32'd0, PHASE_ITEMS / 2);
        random_phase(32'hFFFF_FFFF, PHASE_ITEMS);
        random_phase(32'd1, PHASE_ITEMS / 2);
        random_phase(32'd1000, PHASE_ITEMS);
        random_phase(CAP_RESET, PHASE_ITEMS);
        idle_enabled = 1'b0;
        random_phase(32'd256, PHASE_ITEMS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items over eleven capacity writes, %0d results checked.",
                 items_sent, sb.replies_checked);
        $display("Outcomes: ok %0d, bad %0d, no space %0d, queue full %0d; %0d mismatches.",
                 sb.status_tally[ST_OK], sb.status_tally[ST_BAD],
                 sb.status_tally[ST_NOSPACE], sb.status_tally[ST_QFULL], sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
